### src/scrp_pkg.sv
`default_nettype none

package scrp_pkg;

    // Event codes carried on the operation field.
    localparam logic [2:0] OP_RESET     = 3'd0;
    localparam logic [2:0] OP_WAKE      = 3'd1;
    localparam logic [2:0] OP_PLAN      = 3'd2;
    localparam logic [2:0] OP_SETUP_END = 3'd3;
    localparam logic [2:0] OP_PARK_END  = 3'd4;

    // Probe results.
    localparam logic [1:0] PROBE_ABSENT  = 2'd0;
    localparam logic [1:0] PROBE_READY   = 2'd1;
    localparam logic [1:0] PROBE_IDLE    = 2'd2;
    localparam logic [1:0] PROBE_UNSETUP = 2'd3;

    // Action codes carried on the action field.
    localparam logic [2:0] ACT_SKIP      = 3'd0;
    localparam logic [2:0] ACT_PROBE     = 3'd1;
    localparam logic [2:0] ACT_READ      = 3'd2;
    localparam logic [2:0] ACT_CONFIGURE = 3'd3;
    localparam logic [2:0] ACT_SUSPEND   = 3'd4;
    localparam logic [2:0] ACT_NONE      = 3'd5;

    // Configuration register indexes.
    localparam logic CFG_MAX_CONFIG_TRIES = 1'b0;
    localparam logic CFG_MAX_PARK_TRIES   = 1'b1;

    localparam logic [3:0] TRIES_RESET = 4'd3;

    typedef struct packed {
        logic       abandoned;
        logic       park_pending;
        logic       setup_unfinished;
        logic [3:0] park_tries_used;
        logic [3:0] setup_tries_used;
    } policy_state_t;

endpackage

`default_nettype wire

### src/scrp_policy.sv
`default_nettype none

// Next-state and action decision for one event.
module scrp_policy
(
    input  wire logic [2:0]            operation,
    input  wire logic [1:0]            probe_status,
    input  wire logic                  succeeded,
    input  wire logic [3:0]            max_config_tries,
    input  wire logic [3:0]            max_park_tries,
    input  wire scrp_pkg::policy_state_t cur,
    output scrp_pkg::policy_state_t    nxt,
    output logic [2:0]                 action
);

    logic       park_room;
    logic       setup_room;
    logic [3:0] park_inc;
    logic [3:0] setup_inc;

    assign park_room  = cur.park_tries_used < max_park_tries;
    assign setup_room = cur.setup_tries_used < max_config_tries;
    assign park_inc   = cur.park_tries_used + 4'd1;
    assign setup_inc  = cur.setup_tries_used + 4'd1;

    always_comb
    begin
        nxt    = cur;
        action = scrp_pkg::ACT_NONE;
        case (operation)
            scrp_pkg::OP_RESET:
            begin
                nxt = '0;
            end
            scrp_pkg::OP_WAKE:
            begin
                if (!cur.abandoned)
                begin
                    action = scrp_pkg::ACT_PROBE;
                end
                else if (cur.park_pending && park_room)
                begin
                    nxt.park_tries_used = park_inc;
                    action              = scrp_pkg::ACT_SUSPEND;
                end
                else
                begin
                    nxt.park_pending = 1'b0;
                    action           = scrp_pkg::ACT_SKIP;
                end
            end
            scrp_pkg::OP_PLAN:
            begin
                if (cur.abandoned || probe_status == scrp_pkg::PROBE_ABSENT)
                begin
                    action = scrp_pkg::ACT_SKIP;
                end
                else if (probe_status == scrp_pkg::PROBE_READY && !cur.setup_unfinished)
                begin
                    nxt.setup_tries_used = 4'd0;
                    action               = scrp_pkg::ACT_READ;
                end
                else if (setup_room)
                begin
                    nxt.setup_tries_used = setup_inc;
                    nxt.setup_unfinished = 1'b1;
                    action               = scrp_pkg::ACT_CONFIGURE;
                end
                else
                begin
                    // Budget spent: give up and ask for a park straight away if the park budget allows.
                    nxt.abandoned = 1'b1;
                    if (park_room)
                    begin
                        nxt.park_pending    = 1'b1;
                        nxt.park_tries_used = park_inc;
                        action              = scrp_pkg::ACT_SUSPEND;
                    end
                    else
                    begin
                        nxt.park_pending = 1'b0;
                        action           = scrp_pkg::ACT_SKIP;
                    end
                end
            end
            scrp_pkg::OP_SETUP_END:
            begin
                if (succeeded)
                begin
                    nxt.setup_unfinished = 1'b0;
                    action               = scrp_pkg::ACT_READ;
                end
                else if (!setup_room)
                begin
                    nxt.abandoned = 1'b1;
                    if (park_room)
                    begin
                        nxt.park_pending    = 1'b1;
                        nxt.park_tries_used = park_inc;
                        action              = scrp_pkg::ACT_SUSPEND;
                    end
                    else
                    begin
                        nxt.park_pending = 1'b0;
                        action           = scrp_pkg::ACT_SKIP;
                    end
                end
                else
                begin
                    action = scrp_pkg::ACT_SKIP;
                end
            end
            scrp_pkg::OP_PARK_END:
            begin
                if (succeeded)
                begin
                    nxt.park_pending = 1'b0;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/sensor_config_retry_policy.sv
`default_nettype none

// Channel   Handshake               Payload
// in        in_valid / in_ready     operation[2:0], probe_status[1:0], succeeded
// out       out_valid / out_ready   action[2:0]
// cfg       cfg_valid / cfg_ready   cfg_index[0], cfg_data[3:0]
//
// Each item waits in the input register, where it is decided by
// combinational logic, and its action lands in the result register as the
// policy state updates. One item per cycle is sustained while results are
// taken; the result is offered from the result register. The policy state
// is the only loop and it closes within the decision cycle.
// Reset clears the policy state and the valid flags and loads both limits
// with three. A stalled result holds the decision stage, which in turn stops
// the input side; the configuration port is always ready.
module sensor_config_retry_policy
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] operation,
    input  wire logic [1:0] probe_status,
    input  wire logic       succeeded,

    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [2:0]      action,

    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_index,
    input  wire logic [3:0] cfg_data
);

    // Input register holding the item waiting for a decision.
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [2:0] s1_op_reg;
    logic [1:0] s1_probe_reg;
    logic       s1_ok_reg;

    // Result register.
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [2:0] action_reg;

    // Limits written through the configuration port.
    logic [3:0] max_config_tries_reg;
    logic [3:0] max_park_tries_reg;

    scrp_pkg::policy_state_t state_reg;
    scrp_pkg::policy_state_t state_next;
    logic [2:0]              action_next;

    logic in_fire;
    logic advance;

    // The decision stage moves whenever the result register is free or is
    // being emptied in the same cycle.
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign out_valid = out_valid_reg;
    assign action    = action_reg;

    always_comb
    begin
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    scrp_policy u_policy
    (
        .operation        (s1_op_reg),
        .probe_status     (s1_probe_reg),
        .succeeded        (s1_ok_reg),
        .max_config_tries (max_config_tries_reg),
        .max_park_tries   (max_park_tries_reg),
        .cur              (state_reg),
        .nxt              (state_next),
        .action           (action_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            state_reg            <= '0;
            max_config_tries_reg <= scrp_pkg::TRIES_RESET;
            max_park_tries_reg   <= scrp_pkg::TRIES_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    scrp_pkg::CFG_MAX_CONFIG_TRIES: max_config_tries_reg <= cfg_data;
                    scrp_pkg::CFG_MAX_PARK_TRIES:   max_park_tries_reg   <= cfg_data;
                    default:                        max_park_tries_reg   <= max_park_tries_reg;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg    <= operation;
            s1_probe_reg <= probe_status;
            s1_ok_reg    <= succeeded;
        end
        if (advance)
        begin
            action_reg <= action_next;
        end
    end

    // A reset event leaves the whole policy state cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_op_reg == scrp_pkg::OP_RESET |=> state_reg == '0)
        else $error("policy state not cleared by a reset event");

    // Once given up, the block stays given up until a reset event.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.abandoned && !(advance && s1_op_reg == scrp_pkg::OP_RESET)
        |=> state_reg.abandoned)
        else $error("abandoned flag dropped without a reset event");

    // The configure counter steps by one at most, or returns to zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> state_reg.setup_tries_used == $past(state_reg.setup_tries_used)
                 || state_reg.setup_tries_used == $past(state_reg.setup_tries_used) + 4'd1
                 || state_reg.setup_tries_used == 4'd0)
        else $error("configure counter moved by more than one");

    // A suspend action is only ever offered for a sensor that has been given up.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && action_reg == scrp_pkg::ACT_SUSPEND |-> state_reg.abandoned)
        else $error("suspend offered while the sensor is not given up");

    // A held result with a full input register blocks new items.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !out_ready |-> !in_ready)
        else $error("input accepted while the decision stage is blocked");

endmodule

`default_nettype wire

### verif/tb_top.sv
`default_nettype none

module tb_top;

    // Event codes outside the defined set; the block must answer them with no action.
    localparam logic [2:0] OP_UNDEF_LO  = 3'd5;
    localparam logic [2:0] OP_UNDEF_MID = 3'd6;
    localparam logic [2:0] OP_UNDEF_HI  = 3'd7;

    // Register write masks for the limit update task.
    localparam logic [1:0] SET_CONFIG_LIMIT = 2'b01;
    localparam logic [1:0] SET_PARK_LIMIT   = 2'b10;
    localparam logic [1:0] SET_BOTH_LIMITS  = 2'b11;

    // Quiet cycles tolerated before the run is declared hung. The slowest correct
    // gap between handshakes is a sender burst plus a receiver stall plus the
    // pass through the block, so this is many times over.
    localparam int QUIET_LIMIT  = 400;
    localparam int PHASE_ITEMS  = 50;
    localparam int PHASE_COUNT  = 10;
    localparam int OPENING_ROWS = 24;

    logic       clk;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    logic [2:0] operation    = scrp_pkg::OP_RESET;
    logic [1:0] probe_status = scrp_pkg::PROBE_ABSENT;
    logic       succeeded    = 1'b0;
    logic       out_valid;
    logic       out_ready    = 1'b0;
    logic [2:0] action;
    logic       cfg_valid    = 1'b0;
    logic       cfg_ready;
    logic       cfg_index    = scrp_pkg::CFG_MAX_CONFIG_TRIES;
    logic [3:0] cfg_data     = '0;

    sensor_config_retry_policy uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .probe_status (probe_status),
        .succeeded    (succeeded),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .action       (action),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Our own copy of the policy: the flags and counters, and the two limits.
    scrp_pkg::policy_state_t policy;
    logic [3:0]              config_limit;
    logic [3:0]              park_limit;

    // Actions still owed by the block, oldest first.
    logic [2:0] owed_actions [$];
    int         errors;
    int         defined_sent;
    bit         idling;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // One park attempt: spends a suspend try if a park is pending and the budget
    // allows it, otherwise the pending request is dropped and nothing is done.
    function automatic logic [2:0] park_attempt();
        if (!policy.park_pending || policy.park_tries_used >= park_limit)
        begin
            policy.park_pending = 1'b0;
            return scrp_pkg::ACT_SKIP;
        end
        policy.park_tries_used = policy.park_tries_used + 4'd1;
        return scrp_pkg::ACT_SUSPEND;
    endfunction

    // Giving up is permanent until a reset event, and always asks for a park.
    function automatic logic [2:0] give_up();
        policy.abandoned    = 1'b1;
        policy.park_pending = 1'b1;
        return park_attempt();
    endfunction

    function automatic logic [2:0] policy_step(input logic [2:0] op, input logic [1:0] ps,
                                               input logic ok);
        logic [2:0] act;
        act = scrp_pkg::ACT_NONE;
        case (op)
            scrp_pkg::OP_RESET:
                policy = '0;
            scrp_pkg::OP_WAKE:
                act = policy.abandoned ? park_attempt() : scrp_pkg::ACT_PROBE;
            scrp_pkg::OP_PLAN:
            begin
                if (policy.abandoned || ps == scrp_pkg::PROBE_ABSENT)
                    act = scrp_pkg::ACT_SKIP;
                else if (ps == scrp_pkg::PROBE_READY && !policy.setup_unfinished)
                begin
                    // A healthy sensor with its setup done earns back the whole budget.
                    policy.setup_tries_used = '0;
                    act = scrp_pkg::ACT_READ;
                end
                else if (policy.setup_tries_used >= config_limit)
                    act = give_up();
                else
                begin
                    policy.setup_tries_used = policy.setup_tries_used + 4'd1;
                    policy.setup_unfinished = 1'b1;
                    act = scrp_pkg::ACT_CONFIGURE;
                end
            end
            scrp_pkg::OP_SETUP_END:
            begin
                if (ok)
                begin
                    policy.setup_unfinished = 1'b0;
                    act = scrp_pkg::ACT_READ;
                end
                else if (policy.setup_tries_used >= config_limit)
                    act = give_up();
                else
                    act = scrp_pkg::ACT_SKIP;
            end
            scrp_pkg::OP_PARK_END:
                if (ok)
                    policy.park_pending = 1'b0;
            default:
                ;
        endcase
        return act;
    endfunction

    // Presents one event and holds it until the block takes it. At the accepting
    // edge the predictor advances and the owed action is queued; where the caller
    // has typed an expectation, that value is what the block must produce.
    task automatic send_event(input logic [2:0] op, input logic [1:0] ps, input logic ok,
                              input logic typed, input logic [2:0] typed_act,
                              output logic [2:0] predicted);
        if (idling && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        probe_status <= ps;
        succeeded    <= ok;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = policy_step(op, ps, ok);
        owed_actions.push_back(typed ? typed_act : predicted);
        if (op <= scrp_pkg::OP_PARK_END)
            defined_sent++;
    endtask

    // Stops the sender until every owed action has come back, then lets the
    // two-stage pipeline settle before anything else happens.
    task automatic drain();
        in_valid <= 1'b0;
        while (owed_actions.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Writes one or both limits, back to back, only ever while the block is idle.
    task automatic write_limits(input logic [1:0] mask, input logic [3:0] config_val,
                                input logic [3:0] park_val);
        int i;
        for (i = 0; i < 2; i++)
        begin
            if (mask[i])
            begin
                cfg_valid <= 1'b1;
                cfg_index <= (i == 0) ? scrp_pkg::CFG_MAX_CONFIG_TRIES
                                      : scrp_pkg::CFG_MAX_PARK_TRIES;
                cfg_data  <= (i == 0) ? config_val : park_val;
                @(posedge clk);
                while (!cfg_ready)
                    @(posedge clk);
                if (i == 0)
                    config_limit = config_val;
                else
                    park_limit = park_val;
            end
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [1:0] pick_probe();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4)
            return scrp_pkg::PROBE_READY;
        else if (roll < 6)
            return scrp_pkg::PROBE_IDLE;
        else if (roll < 8)
            return scrp_pkg::PROBE_UNSETUP;
        return scrp_pkg::PROBE_ABSENT;
    endfunction

    // One wake cycle as the firmware would run it: wake, plan on the probe, then
    // report the outcome of whatever configure or suspend was asked for. A few
    // cycles are cut short, a few are plain resets, and some are pure noise.
    task automatic wake_cycle();
        logic [2:0] act;
        int         roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            send_event(scrp_pkg::OP_RESET, 2'($urandom), 1'($urandom), 1'b0,
                       scrp_pkg::ACT_NONE, act);
        else if (roll < 20)
            send_event(3'($urandom), 2'($urandom), 1'($urandom), 1'b0,
                       scrp_pkg::ACT_NONE, act);
        else
        begin
            send_event(scrp_pkg::OP_WAKE, 2'($urandom), 1'($urandom), 1'b0,
                       scrp_pkg::ACT_NONE, act);
            if (act == scrp_pkg::ACT_PROBE)
                send_event(scrp_pkg::OP_PLAN, pick_probe(), 1'($urandom), 1'b0,
                           scrp_pkg::ACT_NONE, act);
            while (act == scrp_pkg::ACT_CONFIGURE || act == scrp_pkg::ACT_SUSPEND)
            begin
                if ($urandom_range(0, 9) == 0)
                    act = scrp_pkg::ACT_NONE;
                else if (act == scrp_pkg::ACT_CONFIGURE)
                    send_event(scrp_pkg::OP_SETUP_END, 2'($urandom), 1'($urandom), 1'b0,
                               scrp_pkg::ACT_NONE, act);
                else
                    send_event(scrp_pkg::OP_PARK_END, 2'($urandom), 1'($urandom), 1'b0,
                               scrp_pkg::ACT_NONE, act);
            end
        end
    endtask

    typedef struct {
        logic [2:0] op;
        logic [1:0] ps;
        logic       ok;
        logic       typed;
        logic [2:0] act;
    } opening_row_t;

    // Walks the budgets down with both limits at three: a configure that fails
    // until the block gives up, suspend tries until the park request is dropped,
    // the undefined events, a reset, and a refund on a ready probe. Rows whose
    // answer is obvious carry it; the rest are left to the predictor.
    opening_row_t opening_steps [OPENING_ROWS] = '{
        '{scrp_pkg::OP_WAKE,      scrp_pkg::PROBE_ABSENT,  1'b0, 1'b1, scrp_pkg::ACT_PROBE},
        '{scrp_pkg::OP_PLAN,      scrp_pkg::PROBE_ABSENT,  1'b1, 1'b1, scrp_pkg::ACT_SKIP},
        '{scrp_pkg::OP_PLAN,      scrp_pkg::PROBE_READY,   1'b0, 1'b1, scrp_pkg::ACT_READ},
        '{scrp_pkg::OP_PLAN,      scrp_pkg::PROBE_IDLE,    1'b0, 1'b0, scrp_pkg::ACT_NONE},
        '{scrp_pkg::OP_SETUP_END, scrp_pkg::PROBE_ABSENT,  1'b0, 1'b0, scrp_pkg::ACT_NONE},
        '{scrp_pkg::OP_PLAN,      scrp_pkg::PROBE_UNSETUP, 1'b1, 1'b0, scrp_pkg::ACT_NONE},
        '{scrp_pkg::OP_PLAN,      scrp_pkg::PROBE_READY,   1'b0, 1'b0, scrp_pkg::ACT_NONE},
        '{scrp_pkg::OP_SETUP_END, scrp_pkg::PROBE_UNSETUP, 1'b0, 1'b0, scrp_pkg::ACT_NONE},
        '{scrp_pkg::OP_WAKE,      scrp_pkg::PROBE_READY,   1'b1, 1'b0, scrp_pkg::ACT_NONE},
        '{scrp_pkg::OP_PARK_END,  scrp_pkg::PROBE_IDLE,    1'b0, 1'b1, scrp_pkg::ACT_NONE},
        '{scrp_pkg::OP_WAKE,      scrp_pkg::PROBE_ABSENT,  1'b0, 1'b0, scrp_pkg::ACT_NONE},
        '{scrp_pkg::OP_WAKE,      scrp_pkg::PROBE_UNSETUP, 1'b1, 1'b0, scrp_pkg::ACT_NONE},
        '{scrp_pkg::OP_PLAN,      scrp_pkg::PROBE_READY,   1'b1, 1'b0, scrp_pkg::ACT_NONE},
        '{scrp_pkg::OP_SETUP_END, scrp_pkg::PROBE_IDLE,    1'b1, 1'b0, scrp_pkg::ACT_NONE},
        '{OP_UNDEF_LO,            scrp_pkg::PROBE_ABSENT,  1'b0, 1'b1, scrp_pkg::ACT_NONE},
        '{OP_UNDEF_MID,           scrp_pkg::PROBE_UNSETUP, 1'b1, 1'b1, scrp_pkg::ACT_NONE},
        '{OP_UNDEF_HI,            scrp_pkg::PROBE_READY,   1'b0, 1'b1, scrp_pkg::ACT_NONE},
        '{scrp_pkg::OP_RESET,     scrp_pkg::PROBE_UNSETUP, 1'b1, 1'b1, scrp_pkg::ACT_NONE},
        '{scrp_pkg::OP_PLAN,      scrp_pkg::PROBE_IDLE,    1'b1, 1'b0, scrp_pkg::ACT_NONE},
        '{scrp_pkg::OP_SETUP_END, scrp_pkg::PROBE_ABSENT,  1'b1, 1'b0, scrp_pkg::ACT_NONE},
        '{scrp_pkg::OP_PLAN,      scrp_pkg::PROBE_READY,   1'b0, 1'b0, scrp_pkg::ACT_NONE},
        '{scrp_pkg::OP_PARK_END,  scrp_pkg::PROBE_READY,   1'b1, 1'b1, scrp_pkg::ACT_NONE},
        '{scrp_pkg::OP_PLAN,      scrp_pkg::PROBE_UNSETUP, 1'b0, 1'b0, scrp_pkg::ACT_NONE},
        '{scrp_pkg::OP_RESET,     scrp_pkg::PROBE_ABSENT,  1'b0, 1'b1, scrp_pkg::ACT_NONE}
    };

    // Main sequence: reset, the opening table, then phases of random wake cycles
    // under a range of limits, the extremes first. The limits are changed without
    // a reset in between, so a counter regularly sits above a freshly lowered
    // limit. Phase four and the last two phases run without any idling on either side.
    initial
    begin
        logic [2:0] act;
        logic [3:0] config_val;
        logic [3:0] park_val;
        logic [1:0] mask;
        int         phase;
        int         row;
        int         target;

        errors       = 0;
        defined_sent = 0;
        idling       = 1'b1;
        policy       = '0;
        config_limit = scrp_pkg::TRIES_RESET;
        park_limit   = scrp_pkg::TRIES_RESET;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < OPENING_ROWS; row++)
            send_event(opening_steps[row].op, opening_steps[row].ps, opening_steps[row].ok,
                       opening_steps[row].typed, opening_steps[row].act, act);

        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    mask = SET_BOTH_LIMITS; config_val = 4'hF; park_val = 4'hF;
                end
                1:
                begin
                    mask = SET_BOTH_LIMITS; config_val = 4'h0; park_val = 4'h0;
                end
                2:
                begin
                    mask = SET_BOTH_LIMITS; config_val = 4'h0; park_val = 4'hF;
                end
                3:
                begin
                    mask = SET_BOTH_LIMITS; config_val = 4'hF; park_val = 4'h0;
                end
                default:
                begin
                    mask       = SET_CONFIG_LIMIT | SET_PARK_LIMIT;
                    if ($urandom_range(0, 2) == 0)
                        mask = ($urandom_range(0, 1) == 0) ? SET_CONFIG_LIMIT : SET_PARK_LIMIT;
                    config_val = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 4))
                                                            : 4'($urandom);
                    park_val   = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 4))
                                                            : 4'($urandom);
                end
            endcase
            write_limits(mask, config_val, park_val);

            idling = !(phase == 4 || phase >= PHASE_COUNT - 2);
            target = defined_sent + PHASE_ITEMS;
            while (defined_sent < target)
            begin
                wake_cycle();
                // Now and then the sender waits for the block to empty mid-phase.
                if ($urandom_range(0, 24) == 0)
                    drain();
            end
        end

        drain();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Receiver: checks each accepted action against the oldest one owed, then
    // decides whether to stall the next cycle. Stalls come in bursts.
    initial
    begin
        logic [2:0] owed;
        int         stall_left;

        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (owed_actions.size() == 0)
                begin
                    $error("action: expected none, actual %0d", action);
                    errors++;
                end
                else
                begin
                    owed = owed_actions.pop_front();
                    if (action !== owed)
                    begin
                        $error("action: expected %0d, actual %0d", owed, action);
                        errors++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idling && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 6);
                out_ready  <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog: a run in which no channel moves for too long has hung.
    initial
    begin
        int quiet;

        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire

### filelist.f
src/scrp_pkg.sv
src/scrp_policy.sv
src/sensor_config_retry_policy.sv
verif/tb_top.sv
